/* src/ptfa_pkg.sv */
// ptfa_pkg: field widths, codes and shared structs of the inverted page table
// used by the channel interfaces, the frame cell and the top level
`timescale 1ns / 1ps

package ptfa_pkg;

  localparam int KIND_W   = 2;
  localparam int PID_W    = 16;
  localparam int PAGE_W   = 28;
  localparam int VA_W     = 32;
  localparam int SIZE_W   = 32;
  localparam int CFG_W    = 5;
  localparam int STATUS_W = 2;
  localparam int FRAME_W  = 6;
  localparam int PA_W     = 22;
  localparam int PG_EXT_W = 33;
  localparam int OFS_W    = 16;

  localparam logic [CFG_W-1:0] SHIFT_MIN   = 5'd4;
  localparam logic [CFG_W-1:0] SHIFT_MAX   = 5'd16;
  localparam logic [CFG_W-1:0] SHIFT_RESET = 5'd12;

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC      = 2'd0,
    KIND_XLATE      = 2'd1,
    KIND_FREE_RANGE = 2'd2,
    KIND_FREE_PROC  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK      = 2'd0,
    STATUS_MISS    = 2'd1,
    STATUS_MAPPED  = 2'd2,
    STATUS_NO_FREE = 2'd3
  } status_t;

  // request as seen by every cell
  typedef struct packed {
    kind_t                kind;
    logic [PID_W-1:0]     pid;
    logic [PAGE_W-1:0]    page;
    logic [PG_EXT_W-1:0]  start_pg;
    logic [PG_EXT_W-1:0]  end_pg;
  } req_t;

  typedef struct packed {
    logic cmp_en;
    logic commit_en;
    logic alloc_go;
  } ctl_t;

  // priority carry passed from cell to cell
  typedef struct packed {
    logic hit;
    logic free;
  } chain_t;

  typedef struct packed {
    logic hit;
    logic free;
  } sel_t;

endpackage

/* src/ptfa_if.sv */
// ptfa_if: valid/ready channel interfaces for requests, results and config
// depends on ptfa_pkg
`timescale 1ns / 1ps

interface ptfa_req_if;
  logic                          valid;
  logic                          ready;
  ptfa_pkg::kind_t               kind;
  logic [ptfa_pkg::PID_W-1:0]    pid;
  logic [ptfa_pkg::PAGE_W-1:0]   page_num;
  logic [ptfa_pkg::VA_W-1:0]     vaddr;
  logic [ptfa_pkg::SIZE_W-1:0]   range_size;

  modport source (output valid, kind, pid, page_num, vaddr, range_size,
                  input ready);
  modport sink (input valid, kind, pid, page_num, vaddr, range_size,
                output ready);
endinterface

interface ptfa_res_if;
  logic                          valid;
  logic                          ready;
  ptfa_pkg::status_t             status;
  logic [ptfa_pkg::FRAME_W-1:0]  frame;
  logic [ptfa_pkg::PA_W-1:0]     physical_address;

  modport source (output valid, status, frame, physical_address, input ready);
  modport sink (input valid, status, frame, physical_address, output ready);
endinterface

interface ptfa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ptfa_pkg::CFG_W-1:0]    page_size_log2;

  modport source (output valid, page_size_log2, input ready);
  modport sink (input valid, page_size_log2, output ready);
endinterface

/* src/ptfa_cell.sv */
// ptfa_cell: one physical frame entry with its compare logic and priority carry
// depends on ptfa_pkg
`timescale 1ns / 1ps

module ptfa_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  ptfa_pkg::req_t    req,
  input  ptfa_pkg::ctl_t    ctl,
  input  ptfa_pkg::chain_t  chain_in,
  output ptfa_pkg::chain_t  chain_out,
  output ptfa_pkg::sel_t    sel
);

  localparam int EW = ptfa_pkg::PG_EXT_W;
  localparam int PW = ptfa_pkg::PAGE_W;

  logic                          valid_r, valid_nxt;
  logic [ptfa_pkg::PID_W-1:0]    pid_r, pid_nxt;
  logic [PW-1:0]                 page_r, page_nxt;
  logic                          hit_r, hit_nxt;
  logic                          free_r, free_nxt;
  logic                          clr_r, clr_nxt;

  logic          pid_eq;
  logic          page_eq;
  logic [EW-1:0] page_ext;
  logic          in_range;

  assign page_ext = {{(EW-PW){1'b0}}, page_r};
  assign pid_eq   = valid_r && (pid_r == req.pid);
  assign page_eq  = (page_r == req.page);
  assign in_range = (page_ext >= req.start_pg) && (page_ext < req.end_pg);

  assign chain_out.hit  = chain_in.hit | hit_r;
  assign chain_out.free = chain_in.free | free_r;
  assign sel.hit        = hit_r & ~chain_in.hit;
  assign sel.free       = free_r & ~chain_in.free;

  always_comb begin
    hit_nxt  = hit_r;
    free_nxt = free_r;
    clr_nxt  = clr_r;
    if (ctl.cmp_en) begin
      hit_nxt  = pid_eq && page_eq;
      free_nxt = ~valid_r;
      clr_nxt  = pid_eq && ((req.kind == ptfa_pkg::KIND_FREE_PROC) ||
                            ((req.kind == ptfa_pkg::KIND_FREE_RANGE) && in_range));
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    pid_nxt   = pid_r;
    page_nxt  = page_r;
    if (ctl.commit_en) begin
      if (ctl.alloc_go && sel.free) begin
        valid_nxt = 1'b1;
        pid_nxt   = req.pid;
        page_nxt  = req.page;
      end else if (clr_r) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pid_r  <= pid_nxt;
    page_r <= page_nxt;
    hit_r  <= hit_nxt;
    free_r <= free_nxt;
    clr_r  <= clr_nxt;
  end

endmodule

/* src/page_table_frame_allocator.sv */
// page_table_frame_allocator: inverted page table built as a chain of frame cells
// a request passes a compare state, then a resolve/commit state where the lowest hit
// and free frame ripple through the cell chain, and the result is then registered; a new
// request is taken in idle or as resolve/commit ends, which stalls while output is held
// reset: all frame valid bits cleared, page shift back to 12, output empty
// depends on ptfa_pkg, ptfa_if, ptfa_cell
`timescale 1ns / 1ps

module page_table_frame_allocator #(
  parameter int NUM_FRAMES = 64,
  parameter int PID_BITS   = 16,
  parameter int VADDR_BITS = 32
) (
  input logic              clk,
  input logic              rst_n,
  ptfa_req_if.sink         in_if,
  ptfa_res_if.source       out_if,
  ptfa_cfg_if.sink         cfg_if
);

  localparam int FRAME_BITS = $clog2(NUM_FRAMES);
  localparam int PIDW       = ptfa_pkg::PID_W;
  localparam int VAW        = ptfa_pkg::VA_W;
  localparam int EW         = ptfa_pkg::PG_EXT_W;
  localparam int PGW        = ptfa_pkg::PAGE_W;
  localparam int OW         = ptfa_pkg::OFS_W;
  localparam int FW         = ptfa_pkg::FRAME_W;
  localparam int PAW        = ptfa_pkg::PA_W;
  localparam int PA_CALC_W  = (FRAME_BITS + OW > PAW) ? FRAME_BITS + OW : PAW;
  localparam int PID_EFF    = (PID_BITS < PIDW) ? PID_BITS : PIDW;
  localparam logic [PIDW-1:0] PID_MASK = PIDW'((64'd1 << PID_EFF) - 64'd1);
  localparam logic [VAW-1:0]  VA_MASK  = VAW'((64'd1 << VADDR_BITS) - 64'd1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_RES  = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  ptfa_pkg::req_t                  req_r, req_nxt;
  logic [OW-1:0]                   offset_r, offset_nxt;
  logic [ptfa_pkg::CFG_W-1:0]      sh_r, sh_nxt;
  logic                            out_valid_r, out_valid_nxt;
  ptfa_pkg::status_t               status_r, status_nxt;
  logic [FW-1:0]                   frame_r, frame_nxt;
  logic [PAW-1:0]                  pa_r, pa_nxt;

  logic             accept;
  logic             done;
  logic [VAW-1:0]   va;
  logic [EW-1:0]    psize_m1;
  logic [EW-1:0]    ceil_sum;
  logic [EW-1:0]    end_sum;
  logic [PGW-1:0]   vpage;

  ptfa_pkg::ctl_t   ctl;
  ptfa_pkg::chain_t chain [NUM_FRAMES+1];
  ptfa_pkg::sel_t   sel   [NUM_FRAMES];
  logic             any_hit;
  logic             any_free;
  logic [FRAME_BITS-1:0] hit_idx;
  logic [FRAME_BITS-1:0] free_idx;
  logic [PA_CALC_W-1:0]  pa_full;

  assign done         = (state_r == ST_RES) && (!out_valid_r || out_if.ready);
  assign in_if.ready  = (state_r == ST_IDLE) || done;
  assign accept       = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;

  assign out_if.valid            = out_valid_r;
  assign out_if.status           = status_r;
  assign out_if.frame            = frame_r;
  assign out_if.physical_address = pa_r;

  // request decode at transfer
  assign va       = in_if.vaddr & VA_MASK;
  assign psize_m1 = (EW'(1) << sh_r) - EW'(1);
  assign ceil_sum = EW'(va) + psize_m1;
  assign end_sum  = EW'(va) + EW'(in_if.range_size);
  assign vpage    = PGW'(va >> sh_r);

  always_comb begin
    req_nxt    = req_r;
    offset_nxt = offset_r;
    if (accept) begin
      req_nxt.kind     = in_if.kind;
      req_nxt.pid      = in_if.pid & PID_MASK;
      req_nxt.page     = (in_if.kind == ptfa_pkg::KIND_ALLOC) ? in_if.page_num : vpage;
      req_nxt.start_pg = ceil_sum >> sh_r;
      req_nxt.end_pg   = end_sum >> sh_r;
      offset_nxt       = OW'(va & VAW'(psize_m1));
    end
  end

  always_comb begin
    sh_nxt = sh_r;
    if (cfg_if.valid && cfg_if.ready) begin
      if (cfg_if.page_size_log2 < ptfa_pkg::SHIFT_MIN) begin
        sh_nxt = ptfa_pkg::SHIFT_MIN;
      end else if (cfg_if.page_size_log2 > ptfa_pkg::SHIFT_MAX) begin
        sh_nxt = ptfa_pkg::SHIFT_MAX;
      end else begin
        sh_nxt = cfg_if.page_size_log2;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_RES;
      end
      ST_RES: begin
        if (done) state_nxt = accept ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // frame cell chain
  assign chain[0].hit  = 1'b0;
  assign chain[0].free = 1'b0;
  assign any_hit       = chain[NUM_FRAMES].hit;
  assign any_free      = chain[NUM_FRAMES].free;

  assign ctl.cmp_en    = (state_r == ST_CMP);
  assign ctl.commit_en = done;
  assign ctl.alloc_go  = (req_r.kind == ptfa_pkg::KIND_ALLOC) && !any_hit;

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    ptfa_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .req       (req_r),
      .ctl       (ctl),
      .chain_in  (chain[g]),
      .chain_out (chain[g+1]),
      .sel       (sel[g])
    );
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      if (sel[i].hit)  hit_idx  = hit_idx | FRAME_BITS'(i);
      if (sel[i].free) free_idx = free_idx | FRAME_BITS'(i);
    end
  end

  assign pa_full = (PA_CALC_W'(hit_idx) << sh_r) | PA_CALC_W'(offset_r);

  always_comb begin
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    frame_nxt     = frame_r;
    pa_nxt        = pa_r;
    if (done) begin
      out_valid_nxt = 1'b1;
      status_nxt    = ptfa_pkg::STATUS_OK;
      frame_nxt     = '0;
      pa_nxt        = '0;
      case (req_r.kind)
        ptfa_pkg::KIND_ALLOC: begin
          if (any_hit) begin
            status_nxt = ptfa_pkg::STATUS_MAPPED;
            frame_nxt  = FW'(hit_idx);
          end else if (!any_free) begin
            status_nxt = ptfa_pkg::STATUS_NO_FREE;
          end else begin
            frame_nxt  = FW'(free_idx);
          end
        end
        ptfa_pkg::KIND_XLATE: begin
          if (any_hit) begin
            frame_nxt = FW'(hit_idx);
            pa_nxt    = PAW'(pa_full);
          end else begin
            status_nxt = ptfa_pkg::STATUS_MISS;
          end
        end
        default: begin
          status_nxt = ptfa_pkg::STATUS_OK;
        end
      endcase
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sh_r        <= ptfa_pkg::SHIFT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sh_r        <= sh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    offset_r <= offset_nxt;
    status_r <= status_nxt;
    frame_r  <= frame_nxt;
    pa_r     <= pa_nxt;
  end

endmodule

/* verif/ptfa_table_monitor.sv */
// ptfa_table_monitor: watches the request, result and page size channels, keeps its own
// copy of the frame table and compares every result transfer in order
// depends on ptfa_pkg and ptfa_if
`timescale 1ns / 1ps

module ptfa_table_monitor (
  input  logic clk,
  input  logic rst_n,
  ptfa_req_if  req_mon,
  ptfa_res_if  res_mon,
  ptfa_cfg_if  cfg_mon,
  output int   mismatches,
  output int   pending
);

  localparam int FRAMES  = 64;
  localparam int PID_W   = ptfa_pkg::PID_W;
  localparam int PAGE_W  = ptfa_pkg::PAGE_W;
  localparam int VA_W    = ptfa_pkg::VA_W;
  localparam int SIZE_W  = ptfa_pkg::SIZE_W;
  localparam int CFG_W   = ptfa_pkg::CFG_W;
  localparam int FRAME_W = ptfa_pkg::FRAME_W;
  localparam int PA_W    = ptfa_pkg::PA_W;

  typedef struct packed {
    ptfa_pkg::status_t   status;
    logic [FRAME_W-1:0]  frame;
    logic [PA_W-1:0]     paddr;
  } table_reply_t;

  logic               frame_used  [FRAMES];
  logic [PID_W-1:0]   frame_owner [FRAMES];
  logic [PAGE_W-1:0]  frame_vpn   [FRAMES];
  logic [CFG_W-1:0]   page_log2;
  table_reply_t       replies_due [$];

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("mismatch on %s: got %0h, expected %0h, at %0t", what, got, want, $time);
  endtask

  function automatic table_reply_t apply_table_op(ptfa_pkg::kind_t op, logic [PID_W-1:0] pid,
                                                  logic [PAGE_W-1:0] vpn,
                                                  logic [VA_W-1:0] va,
                                                  logic [SIZE_W-1:0] len);
    table_reply_t r;
    int hit;
    int free_slot;
    int sh;
    logic [63:0] start_b;
    logic [63:0] end_b;
    logic [63:0] base_b;
    logic [63:0] psize;
    logic [63:0] offset;
    r.status = ptfa_pkg::STATUS_OK;
    r.frame = '0;
    r.paddr = '0;
    hit = -1;
    free_slot = -1;
    if (page_log2 < ptfa_pkg::SHIFT_MIN) sh = int'(ptfa_pkg::SHIFT_MIN);
    else if (page_log2 > ptfa_pkg::SHIFT_MAX) sh = int'(ptfa_pkg::SHIFT_MAX);
    else sh = int'(page_log2);
    psize = 64'd1 << sh;
    case (op)
      ptfa_pkg::KIND_ALLOC: begin
        for (int i = 0; i < FRAMES; i++) begin
          if (frame_used[i]) begin
            if (hit < 0 && frame_owner[i] == pid && frame_vpn[i] == vpn) hit = i;
          end else if (free_slot < 0) begin
            free_slot = i;
          end
        end
        if (hit >= 0) begin
          r.status = ptfa_pkg::STATUS_MAPPED;
          r.frame = FRAME_W'(hit);
        end else if (free_slot < 0) begin
          r.status = ptfa_pkg::STATUS_NO_FREE;
        end else begin
          frame_used[free_slot] = 1'b1;
          frame_owner[free_slot] = pid;
          frame_vpn[free_slot] = vpn;
          r.frame = FRAME_W'(free_slot);
        end
      end
      ptfa_pkg::KIND_XLATE: begin
        for (int i = 0; i < FRAMES; i++) begin
          if (hit < 0 && frame_used[i] && frame_owner[i] == pid &&
              frame_vpn[i] == PAGE_W'({32'd0, va} >> sh)) begin
            hit = i;
          end
        end
        if (hit < 0) begin
          r.status = ptfa_pkg::STATUS_MISS;
        end else begin
          offset = {32'd0, va} & (psize - 64'd1);
          r.frame = FRAME_W'(hit);
          r.paddr = PA_W'((64'(hit) << sh) + offset);
        end
      end
      ptfa_pkg::KIND_FREE_RANGE: begin
        start_b = {32'd0, va};
        end_b = start_b + {32'd0, len};
        for (int i = 0; i < FRAMES; i++) begin
          if (frame_used[i] && frame_owner[i] == pid) begin
            base_b = {36'd0, frame_vpn[i]} << sh;
            if (base_b >= start_b && base_b + psize <= end_b) frame_used[i] = 1'b0;
          end
        end
      end
      default: begin
        for (int i = 0; i < FRAMES; i++) begin
          if (frame_used[i] && frame_owner[i] == pid) frame_used[i] = 1'b0;
        end
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < FRAMES; i++) begin
        frame_used[i] = 1'b0;
      end
      page_log2 = ptfa_pkg::SHIFT_RESET;
      replies_due.delete();
      mismatches = 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result transfer with none expected", res_mon.status, 0);
        end else begin
          want = replies_due.pop_front();
          if (res_mon.status !== want.status)
            report_mismatch("status", res_mon.status, want.status);
          if (res_mon.frame !== want.frame)
            report_mismatch("frame", res_mon.frame, want.frame);
          if (res_mon.physical_address !== want.paddr)
            report_mismatch("physical_address", res_mon.physical_address, want.paddr);
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) page_log2 = cfg_mon.page_size_log2;
      if (req_mon.valid && req_mon.ready) begin
        replies_due.insert(replies_due.size(),
                           apply_table_op(req_mon.kind, req_mon.pid, req_mon.page_num,
                                          req_mon.vaddr, req_mon.range_size));
      end
    end
    pending = replies_due.size();
  end

endmodule

/* verif/tb.sv */
// tb: drives requests and page size writes into page_table_frame_allocator with random
// gaps and output stalls, and reports the verdict from ptfa_table_monitor
// depends on ptfa_pkg, ptfa_if, page_table_frame_allocator and ptfa_table_monitor
`timescale 1ns / 1ps

module tb;

  localparam int PID_W  = ptfa_pkg::PID_W;
  localparam int PAGE_W = ptfa_pkg::PAGE_W;
  localparam int VA_W   = ptfa_pkg::VA_W;
  localparam int SIZE_W = ptfa_pkg::SIZE_W;
  localparam int CFG_W  = ptfa_pkg::CFG_W;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   pending;

  ptfa_req_if req_ch ();
  ptfa_res_if res_ch ();
  ptfa_cfg_if cfg_ch ();

  page_table_frame_allocator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (req_ch),
    .out_if (res_ch),
    .cfg_if (cfg_ch)
  );

  ptfa_table_monitor table_mon (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_mon    (req_ch),
    .res_mon    (res_ch),
    .cfg_mon    (cfg_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  int               eff_shift;
  bit               tx_smooth;
  bit               tx_burst;
  bit               rx_smooth;
  bit               rx_hold_req;
  int               kind_count [4];
  int               cfg_writes;
  logic [PID_W-1:0] pid_pool [4];
  int unsigned      page_base;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls, smooth stretches and one long hold-off
  initial begin
    int stall;
    bit held;
    held = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      if (rx_hold_req && !held) begin
        held = 1'b1;
        @(negedge clk);
        res_ch.ready <= 1'b0;
        repeat (300) @(negedge clk);
      end
      stall = rx_smooth ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        @(negedge clk);
        res_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!res_ch.valid);
    end
  end

  task automatic send_req(ptfa_pkg::kind_t op, logic [PID_W-1:0] pid,
                          logic [PAGE_W-1:0] vpn,
                          logic [VA_W-1:0] va, logic [SIZE_W-1:0] len);
    int gap;
    gap = (tx_smooth || tx_burst) ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.kind       <= op;
    req_ch.pid        <= pid;
    req_ch.page_num   <= vpn;
    req_ch.vaddr      <= va;
    req_ch.range_size <= len;
    do @(posedge clk); while (!req_ch.ready);
    kind_count[int'(op)]++;
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_page_size(logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.page_size_log2 <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (v < ptfa_pkg::SHIFT_MIN) eff_shift = int'(ptfa_pkg::SHIFT_MIN);
    else if (v > ptfa_pkg::SHIFT_MAX) eff_shift = int'(ptfa_pkg::SHIFT_MAX);
    else eff_shift = int'(v);
    cfg_writes++;
  endtask

  task automatic random_req();
    ptfa_pkg::kind_t   op;
    logic [PID_W-1:0]  pid;
    logic [PAGE_W-1:0] vpn;
    logic [VA_W-1:0]   va;
    logic [SIZE_W-1:0] len;
    logic [63:0]       base;
    int unsigned       roll;
    roll = $urandom_range(0, 99);
    if (roll < 38) op = ptfa_pkg::KIND_ALLOC;
    else if (roll < 75) op = ptfa_pkg::KIND_XLATE;
    else if (roll < 94) op = ptfa_pkg::KIND_FREE_RANGE;
    else op = ptfa_pkg::KIND_FREE_PROC;
    pid = ($urandom_range(0, 9) == 0) ? PID_W'($urandom) : pid_pool[$urandom_range(0, 3)];
    vpn = ($urandom_range(0, 9) == 0) ? PAGE_W'($urandom)
                                      : PAGE_W'(page_base + $urandom_range(0, 15));
    va = $urandom;
    len = $urandom;
    base = {36'd0, vpn} << eff_shift;
    if (op == ptfa_pkg::KIND_XLATE && $urandom_range(0, 4) != 0) begin
      va = VA_W'(base | (64'($urandom) & ((64'd1 << eff_shift) - 64'd1)));
    end
    if (op == ptfa_pkg::KIND_FREE_RANGE) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        len = '0;
      end else if (roll < 85) begin
        va = VA_W'(base);
        len = SIZE_W'(64'($urandom_range(1, 6)) << eff_shift);
        case ($urandom_range(0, 4))
          0: va = va + 1;
          1: len = len - 1;
          2: len = len + 1;
          default: ;
        endcase
      end
    end
    if (op != ptfa_pkg::KIND_ALLOC) vpn = PAGE_W'($urandom);
    send_req(op, pid, vpn, va, len);
  endtask

  initial begin
    logic [CFG_W-1:0] shift_plan [8];
    logic [PID_W-1:0] fill_pid;
    rst_n                  = 1'b0;
    req_ch.valid           = 1'b0;
    req_ch.kind            = ptfa_pkg::KIND_ALLOC;
    req_ch.pid             = '0;
    req_ch.page_num        = '0;
    req_ch.vaddr           = '0;
    req_ch.range_size      = '0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.page_size_log2  = ptfa_pkg::SHIFT_RESET;
    eff_shift   = int'(ptfa_pkg::SHIFT_RESET);
    tx_smooth   = 1'b0;
    tx_burst    = 1'b0;
    rx_smooth   = 1'b0;
    rx_hold_req = 1'b0;
    cfg_writes  = 0;
    page_base   = 0;
    foreach (kind_count[k]) kind_count[k] = 0;
    shift_plan = '{5'd4, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3, 5'd9, 5'd12};
    shift_plan[6] = CFG_W'($urandom_range(5, 15));
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed checks at the reset page size of 4 KiB
    send_req(ptfa_pkg::KIND_ALLOC, 16'h0000, 28'h0000000, 32'h0, 32'h0);
    send_req(ptfa_pkg::KIND_ALLOC, 16'hFFFF, 28'hFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_req(ptfa_pkg::KIND_ALLOC, 16'h0000, 28'h0000000, 32'h0, 32'h0);
    send_req(ptfa_pkg::KIND_XLATE, 16'h0000, 28'h0, 32'h00000ABC, 32'h0);
    send_req(ptfa_pkg::KIND_XLATE, 16'hFFFF, 28'hFFFFFFF, 32'hFFFFFFFF, 32'h0);
    send_req(ptfa_pkg::KIND_XLATE, 16'h0001, 28'h0, 32'h0, 32'h0);
    send_req(ptfa_pkg::KIND_ALLOC, 16'h0000, 28'h1, 32'h0, 32'h0);
    send_req(ptfa_pkg::KIND_ALLOC, 16'h0000, 28'h2, 32'h0, 32'h0);
    send_req(ptfa_pkg::KIND_ALLOC, 16'h0000, 28'h3, 32'h0, 32'h0);
    // aligned first page and a page ending exactly at the range end
    send_req(ptfa_pkg::KIND_FREE_RANGE, 16'h0000, 28'h0, 32'h00001000, 32'h00002000);
    send_req(ptfa_pkg::KIND_XLATE, 16'h0000, 28'h0, 32'h00001004, 32'h0);
    send_req(ptfa_pkg::KIND_XLATE, 16'h0000, 28'h0, 32'h00002FFF, 32'h0);
    send_req(ptfa_pkg::KIND_FREE_RANGE, 16'h0000, 28'h0, 32'h0, 32'h0);
    send_req(ptfa_pkg::KIND_FREE_RANGE, 16'h0000, 28'h0, 32'h00000001, 32'h00003FFE);
    send_req(ptfa_pkg::KIND_XLATE, 16'h0000, 28'h0, 32'h00003123, 32'h0);
    send_req(ptfa_pkg::KIND_FREE_RANGE, 16'hFFFF, 28'h0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_req(ptfa_pkg::KIND_ALLOC, 16'h0000, 28'h1, 32'h0, 32'h0);
    send_req(ptfa_pkg::KIND_FREE_PROC, 16'h0000, 28'h0, 32'h0, 32'h0);
    send_req(ptfa_pkg::KIND_XLATE, 16'h0000, 28'h0, 32'h0, 32'h0);
    send_req(ptfa_pkg::KIND_FREE_PROC, 16'hFFFF, 28'h0, 32'h0, 32'h0);
    send_req(ptfa_pkg::KIND_ALLOC, 16'hFFFF, 28'h00FFFFF, 32'h0, 32'h0);
    send_req(ptfa_pkg::KIND_XLATE, 16'hFFFF, 28'h0, 32'hFFFFFFFF, 32'h0);
    // range end lands on 2^32 without wrapping
    send_req(ptfa_pkg::KIND_FREE_RANGE, 16'hFFFF, 28'h0, 32'hFFFFF000, 32'h00001000);
    send_req(ptfa_pkg::KIND_XLATE, 16'hFFFF, 28'h0, 32'hFFFFFFFF, 32'h0);
    drain();

    foreach (shift_plan[p]) begin
      write_page_size(shift_plan[p]);
      pid_pool[0] = (p % 2 == 0) ? 16'h0000 : 16'hFFFF;
      for (int i = 1; i < 4; i++) pid_pool[i] = PID_W'($urandom);
      page_base = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4000) : 0;
      tx_smooth = (p % 3 == 1);
      rx_smooth = (p % 3 == 2);
      if (p == 1) begin
        // fill every frame, overflow twice, then hit each one at the top offset
        fill_pid = PID_W'($urandom);
        for (int i = 0; i < 66; i++) begin
          send_req(ptfa_pkg::KIND_ALLOC, fill_pid, PAGE_W'(i), $urandom, $urandom);
        end
        for (int i = 0; i < 64; i++) begin
          send_req(ptfa_pkg::KIND_XLATE, fill_pid, PAGE_W'($urandom),
                   VA_W'((64'(i) << eff_shift) | ((64'd1 << eff_shift) - 64'd1)), $urandom);
        end
        send_req(ptfa_pkg::KIND_FREE_PROC, fill_pid, PAGE_W'($urandom), $urandom, $urandom);
      end
      if (p == 2) begin
        // result side holds off while requests keep coming
        rx_hold_req = 1'b1;
        tx_burst = 1'b1;
        repeat (30) random_req();
        tx_burst = 1'b0;
      end
      repeat (140) random_req();
      drain();
    end

    repeat (10) @(negedge clk);
    $display("covered %0d requests: %0d allocate, %0d translate, %0d range free, %0d process free",
             kind_count[0] + kind_count[1] + kind_count[2] + kind_count[3],
             kind_count[0], kind_count[1], kind_count[2], kind_count[3]);
    $display("page size register written %0d times, clamped values and a full table included",
             cfg_writes);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
src/ptfa_pkg.sv
src/ptfa_if.sv
src/ptfa_cell.sv
src/page_table_frame_allocator.sv
verif/ptfa_table_monitor.sv
verif/tb.sv
